>>> rtl/core/mdt_pkg.sv
// ----------------------------------------------------------------------------
// Multi-delimiter tokenizer package
// Shared constants, codes and types of the tokenizer blocks.
// ----------------------------------------------------------------------------
package mdt_pkg;

    localparam int DELIM_SLOTS   = 4;
    localparam int MAX_DELIM_LEN = 4;
    localparam int CHAR_BITS     = 16;

    localparam int TEXT_W  = 64;
    localparam int LEN_W   = 3;
    localparam int CNT_W   = 3;
    localparam int FIELD_W = 16;
    localparam int IDX_W   = 3;
    localparam int WIN_W   = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_TEXT_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_TEXT_3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEN_0  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LEN_3  = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_DELIM = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    typedef struct packed {
        logic [3:0][TEXT_W-1:0] text;
        logic [3:0][LEN_W-1:0]  len;
    } mdt_cfg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] ch;
        logic [1:0]         kind;
        logic               last;
    } mdt_res_t;

    typedef logic [MAX_DELIM_LEN-1:0][CHAR_BITS-1:0] mdt_win_t;

endpackage

>>> rtl/core/mdt_cfg.sv
// ----------------------------------------------------------------------------
// Tokenizer configuration registers
// Holds the delimiter texts and lengths written through the write port.
// ----------------------------------------------------------------------------
module mdt_cfg
    import mdt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [TEXT_W-1:0] cfg_wdata,
    output mdt_cfg_t          cfg
);

    mdt_cfg_t cfg_reg;
    mdt_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index) inside
                [REG_TEXT_0:REG_TEXT_3]: cfg_next.text[cfg_index[1:0]] = cfg_wdata;
                [REG_LEN_0:REG_LEN_3]:   cfg_next.len[cfg_index[1:0]]  = cfg_wdata[LEN_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/mdt_core.sv
// ----------------------------------------------------------------------------
// Tokenizer window and match logic
// Appends characters to the lookahead window, tests the delimiter slots at
// the window head and produces one result per step; drains at string end.
// ----------------------------------------------------------------------------
module mdt_core
    import mdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mdt_cfg_t             cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FIELD_W-1:0]   in_char,
    input  logic                 in_last,
    input  logic                 buf_ready,
    output logic                 res_valid,
    output mdt_res_t             res
);

    mdt_win_t         win_reg;
    mdt_win_t         win_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             open_reg;
    logic             open_next;
    logic             drain_reg;
    logic             drain_next;

    mdt_win_t         w;
    mdt_win_t         w_shift;
    logic [CNT_W-1:0] c;
    logic [LEN_W-1:0] mlen;
    logic [CNT_W-1:0] drop;
    logic [CNT_W-1:0] rem;
    logic             accept;
    logic             end_mode;
    logic             step_on;
    logic             final_on;
    logic             done;
    logic [DELIM_SLOTS-1:0] slot_hit;

    assign in_ready = !drain_reg && buf_ready;
    assign accept   = in_valid && in_ready;
    assign end_mode = drain_reg || in_last;

    // Window as seen by this cycle's step: append the new character
    always_comb
    begin
        w = win_reg;
        c = cnt_reg;
        if (!drain_reg)
        begin
            w[cnt_reg[WIN_W-1:0]] = in_char[CHAR_BITS-1:0];
            c = cnt_reg + CNT_W'(1);
        end
    end

    // Parallel compare of every slot against the window head
    always_comb
    begin
        for (int s = 0; s < DELIM_SLOTS; s++)
        begin
            slot_hit[s] = (cfg.len[s] != '0)
                       && (cfg.len[s] <= LEN_W'(MAX_DELIM_LEN))
                       && (cfg.len[s] <= c);
            for (int k = 0; k < MAX_DELIM_LEN; k++)
            begin
                if ((LEN_W'(k) < cfg.len[s])
                    && (cfg.text[s][FIELD_W*k +: CHAR_BITS] != w[k]))
                begin
                    slot_hit[s] = 1'b0;
                end
            end
        end
        // Lowest slot wins
        mlen = '0;
        for (int s = DELIM_SLOTS - 1; s >= 0; s--)
        begin
            if (slot_hit[s])
            begin
                mlen = cfg.len[s];
            end
        end
    end

    assign drop = (mlen != '0) ? mlen : CNT_W'(1);
    assign rem  = c - drop;
    assign done = (rem == '0) && (mlen != '0);

    always_comb
    begin
        w_shift = w;
        for (int i = 0; i < MAX_DELIM_LEN; i++)
        begin
            for (int d = 1; d < MAX_DELIM_LEN; d++)
            begin
                if ((drop == CNT_W'(d)) && (i + d < MAX_DELIM_LEN))
                begin
                    w_shift[i] = w[i + d];
                end
            end
        end
    end

    assign step_on  = buf_ready
                   && ((drain_reg && (cnt_reg != '0))
                       || (accept && (in_last || (c == CNT_W'(MAX_DELIM_LEN)))));
    assign final_on = buf_ready && drain_reg && (cnt_reg == '0);

    always_comb
    begin
        res_valid = step_on || final_on;
        res.ch    = '0;
        res.kind  = KIND_CHAR;
        res.last  = 1'b1;
        if (final_on)
        begin
            res.kind = KIND_END;
        end
        else
        begin
            if (mlen != '0)
            begin
                res.kind = KIND_DELIM;
            end
            else
            begin
                res.ch = FIELD_W'(w[0]);
            end
            res.last = !end_mode || done;
        end
    end

    always_comb
    begin
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        open_next  = open_reg;
        drain_next = drain_reg;
        if (final_on)
        begin
            drain_next = 1'b0;
            open_next  = 1'b0;
        end
        else if (step_on)
        begin
            win_next  = w_shift;
            cnt_next  = rem;
            open_next = (mlen == '0);
            if (end_mode)
            begin
                drain_next = !done;
            end
        end
        else if (accept)
        begin
            win_next = w;
            cnt_next = c;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            open_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            open_reg  <= open_next;
            drain_reg <= drain_next;
        end
    end

    // Outside a drain the window never holds a full set of characters
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !drain_reg |-> (cnt_reg < CNT_W'(MAX_DELIM_LEN)))
        else $error("window count out of range outside drain");

    // A drain ends only on a result that closes the string
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(drain_reg) |-> $past(res_valid && res.last))
        else $error("drain ended without a closing result");

    // The end-of-string mark is always the closing result
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == KIND_END)) |-> res.last)
        else $error("end mark not flagged last");

    // Idle cycles leave the window untouched
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!drain_reg && !accept) |=> ($stable(cnt_reg) && !drain_reg))
        else $error("window changed without a transfer");

endmodule

>>> rtl/core/mdt_out_buf.sv
// ----------------------------------------------------------------------------
// Tokenizer result buffer
// Output register with a skid stage so a result can be taken in while the
// previous one is stalled.
// ----------------------------------------------------------------------------
module mdt_out_buf
    import mdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mdt_res_t push_data,
    output logic     push_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output mdt_res_t out_data
);

    logic     main_valid_reg;
    logic     main_valid_next;
    mdt_res_t main_reg;
    mdt_res_t main_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    mdt_res_t skid_reg;
    mdt_res_t skid_next;

    assign push_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            // Hold the stalled result, park the new one
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

>>> rtl/core/multi_delimiter_tokenizer.sv
// ----------------------------------------------------------------------------
// Multi-delimiter tokenizer
// Splits a character stream into tokens at up to four configured delimiters.
// ----------------------------------------------------------------------------
// The block takes one 16-bit character per cycle while not draining and the
// buffer has room, and keeps a four-character lookahead window; once the
// window is full, each character transfer yields at most one result, so a
// string streams at one character per clock. The transfer that carries tlast
// starts a drain of the window, with the input held off: one result per
// cycle while the buffer has room (token characters, token-end marks, then a
// final-token mark when a token is open). Results carry tlast on the last
// result caused by an input character. Write the delimiter registers only
// while the block is idle; a slot of length zero or above four is disabled.
module multi_delimiter_tokenizer
    import mdt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] in_char
    input  logic              s_tlast,   // in_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [15:0] out_char
    output logic [1:0]        m_tuser,   // [1:0] out_kind
    output logic              m_tlast,   // out_last
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [TEXT_W-1:0] cfg_wdata
);

    mdt_cfg_t cfg;
    logic     res_valid;
    mdt_res_t res;
    logic     buf_ready;
    mdt_res_t out_data;

    mdt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mdt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .buf_ready (buf_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    mdt_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .push_ready (buf_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = out_data.ch;
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Multi-delimiter tokenizer testbench
// Streams strings into the tokenizer under several delimiter setups and checks
// every token character, token-end and final-token mark against a local model
// of the splitter. Both sides idle at random in two of three idling phases.
// ----------------------------------------------------------------------------
module tb;
    import mdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETUPS       = 6;
    localparam int RAND_CHARS   = 52;   // minimum random characters per setup
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [FIELD_W-1:0] ch;
        logic               last;
    } char_item_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [TEXT_W-1:0] cfg_wdata = '0;

    // Delimiter setup as the block holds it, and the next setup to load
    logic [TEXT_W-1:0]    delim_text_sh [4];
    logic [LEN_W-1:0]     delim_len_sh  [4];
    logic [TEXT_W-1:0]    plan_text     [4];
    logic [LEN_W-1:0]     plan_len      [4];

    // Splitter state of the model
    logic [CHAR_BITS-1:0] win [MAX_DELIM_LEN];
    int                   win_cnt  = 0;
    logic                 tok_open = 1'b0;

    char_item_t char_q [$];
    mdt_res_t   token_q [$];
    char_item_t next_char;
    int         queued_cnt = 0;
    int         err_cnt    = 0;
    int         send_idle  = 0;
    int         recv_idle  = 0;
    logic       s_fire     = 1'b0;

    multi_delimiter_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the splitter
    // ------------------------------------------------------------------------

    // Length of the first enabled slot that matches at the window head, or 0
    function automatic int delim_hit_len();
        int   s;
        int   k;
        int   n;
        logic ok;
        for (s = 0; s < DELIM_SLOTS; s++)
        begin
            n = int'(delim_len_sh[s]);
            if (n != 0 && n <= MAX_DELIM_LEN && n <= win_cnt)
            begin
                ok = 1'b1;
                for (k = 0; k < n; k++)
                    if (delim_text_sh[s][16*k +: CHAR_BITS] != win[k])
                        ok = 1'b0;
                if (ok)
                    return n;
            end
        end
        return 0;
    endfunction

    function automatic void drop_head(int cnt);
        int i;
        for (i = 0; i + cnt < win_cnt; i++)
            win[i] = win[i + cnt];
        win_cnt -= cnt;
    endfunction

    function automatic mdt_res_t token_mark(logic [FIELD_W-1:0] ch, logic [1:0] kind);
        mdt_res_t r;
        r.ch   = ch;
        r.kind = kind;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void split_char(logic [15:0] ch, logic last);
        mdt_res_t res [0:7];
        int       n;
        int       hit;
        int       i;
        n = 0;
        if (win_cnt < MAX_DELIM_LEN)
        begin
            win[win_cnt] = ch[CHAR_BITS-1:0];
            win_cnt++;
        end
        while (win_cnt == MAX_DELIM_LEN || (last && win_cnt > 0))
        begin
            hit = delim_hit_len();
            if (hit != 0)
            begin
                res[n] = token_mark('0, KIND_DELIM);
                drop_head(hit);
                tok_open = 1'b0;
            end
            else
            begin
                res[n] = token_mark(FIELD_W'(win[0]), KIND_CHAR);
                drop_head(1);
                tok_open = 1'b1;
            end
            n++;
        end
        if (last)
        begin
            // Close the final token only if it holds characters
            if (tok_open)
            begin
                res[n] = token_mark('0, KIND_END);
                n++;
            end
            tok_open = 1'b0;
            win_cnt  = 0;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (i = 0; i < n; i++)
            token_q.push_back(res[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------------

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            // Hold the current transfer until it is taken
            if (!s_tvalid || s_fire)
            begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    next_char = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_char.ch;
                    s_tlast  <= next_char.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_fire <= 1'b0;
        end
        else
        begin
            s_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                split_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (token_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected result: ch=%h kind=%0d last=%0d",
                                 m_tdata, m_tuser, m_tlast);
                    err_cnt++;
                end
                else if (token_q[0].ch !== m_tdata || token_q[0].kind !== m_tuser ||
                         token_q[0].last !== m_tlast)
                begin
                    if (err_cnt < 10)
                        $display("mismatch: expected ch=%h kind=%0d last=%0d,",
                                 token_q[0].ch, token_q[0].kind, token_q[0].last,
                                 " got ch=%h kind=%0d last=%0d",
                                 m_tdata, m_tuser, m_tlast);
                    err_cnt++;
                    void'(token_q.pop_front());
                end
                else
                begin
                    void'(token_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [TEXT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx >= REG_LEN_0)
            delim_len_sh[idx - REG_LEN_0] = val[LEN_W-1:0];
        else
            delim_text_sh[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup();
        int s;
        for (s = 0; s < 4; s++)
            write_reg(IDX_W'(REG_TEXT_0 + s), plan_text[s]);
        for (s = 0; s < 4; s++)
            write_reg(IDX_W'(REG_LEN_0 + s), {{(TEXT_W-LEN_W){1'b0}}, plan_len[s]});
    endtask

    function automatic logic [TEXT_W-1:0] pack_delim(string txt);
        logic [TEXT_W-1:0] r;
        int                i;
        r = '0;
        for (i = 0; i < txt.len() && i < MAX_DELIM_LEN; i++)
            r[16*i +: 16] = {8'h00, txt[i]};
        return r;
    endfunction

    function automatic logic [15:0] pool_char();
        return 16'h0061 + 16'($urandom_range(2));
    endfunction

    function automatic logic [TEXT_W-1:0] pool_delim();
        return {pool_char(), pool_char(), pool_char(), pool_char()};
    endfunction

    task automatic push_char(logic [15:0] ch, logic last);
        char_item_t it;
        it.ch   = ch;
        it.last = last;
        char_q.push_back(it);
        queued_cnt++;
    endtask

    task automatic queue_text(string txt);
        int i;
        for (i = 0; i < txt.len(); i++)
            push_char({8'h00, txt[i]}, i == txt.len() - 1);
    endtask

    // Mostly strings built from delimiters and their characters; some noise
    // with random characters and early string ends
    task automatic queue_random_string();
        logic [15:0] cq [$];
        int          pieces;
        int          p;
        int          s;
        int          k;
        int          n;
        int          roll;
        logic        noise;
        noise  = ($urandom_range(99) < 15);
        pieces = $urandom_range(1, 10);
        for (p = 0; p < pieces; p++)
        begin
            roll = $urandom_range(9);
            s    = $urandom_range(3);
            k    = $urandom_range(3);
            if (noise || roll == 9)
            begin
                cq.push_back(16'($urandom_range(16'hFFFF)));
            end
            else if (roll < 4)
            begin
                n = int'(delim_len_sh[s]);
                if (n < 1 || n > MAX_DELIM_LEN)
                    n = $urandom_range(1, MAX_DELIM_LEN);
                // Cut some delimiters short to break the match
                if (roll == 0)
                    n = $urandom_range(1, n);
                for (k = 0; k < n; k++)
                    cq.push_back(delim_text_sh[s][16*k +: 16]);
            end
            else if (roll < 7)
            begin
                cq.push_back(delim_text_sh[s][16*k +: 16]);
            end
            else
            begin
                cq.push_back(pool_char());
            end
        end
        for (k = 0; k < cq.size(); k++)
            push_char(cq[k], (k == cq.size() - 1) || (noise && $urandom_range(3) == 0));
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || s_tvalid || token_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int ph;
        int s;
        int target;
        for (s = 0; s < 4; s++)
        begin
            delim_text_sh[s] = '0;
            delim_len_sh[s]  = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < SETUPS; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle = 34;
                    recv_idle = 62;
                end
                1:
                begin
                    send_idle = 62;
                    recv_idle = 34;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase

            case (ph)
                0:
                begin
                    // Double comma ahead of single comma tests slot priority;
                    // the last slot is disabled by an oversized length
                    plan_text[0] = pack_delim(",,");
                    plan_text[1] = pack_delim(",");
                    plan_text[2] = pack_delim("abcd");
                    plan_text[3] = pack_delim("x");
                    plan_len     = '{3'd2, 3'd1, 3'd4, 3'd5};
                end
                1:
                begin
                    // No delimiter enabled
                    for (s = 0; s < 4; s++)
                    begin
                        plan_text[s] = '1;
                        plan_len[s]  = '0;
                    end
                end
                2:
                begin
                    for (s = 0; s < 4; s++)
                    begin
                        plan_text[s] = pool_delim();
                        plan_len[s]  = 3'd4;
                    end
                end
                3:
                begin
                    for (s = 0; s < 4; s++)
                    begin
                        plan_text[s] = pool_delim();
                        plan_len[s]  = LEN_W'(s + 1);
                    end
                end
                4:
                begin
                    for (s = 0; s < 4; s++)
                    begin
                        plan_text[s] = pool_delim();
                        plan_len[s]  = LEN_W'($urandom_range(7));
                    end
                end
                default:
                begin
                    plan_text[0] = '0;
                    plan_text[1] = '1;
                    plan_text[2] = pool_delim();
                    plan_text[3] = pool_delim();
                    plan_len     = '{3'd1, 3'd4, 3'd2, 3'd7};
                end
            endcase
            load_setup();

            if (ph == 0)
            begin
                push_char(16'h0000, 1'b1);
                push_char(16'hFFFF, 1'b1);
                queue_text(",");        // lone delimiter, no trailing empty token
                queue_text("a,,,b");    // priority and adjacent delimiters
                queue_text("abcde");
                queue_text("abc");      // short tail against a long delimiter
                queue_text("xx");       // disabled slot
                queue_text(",ab,");
            end

            target = queued_cnt + RAND_CHARS;
            while (queued_cnt < target)
                queue_random_string();
            wait_drained();
        end

        if (err_cnt == 0 && token_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
rtl/core/mdt_pkg.sv
rtl/core/mdt_cfg.sv
rtl/core/mdt_core.sv
rtl/core/mdt_out_buf.sv
rtl/core/multi_delimiter_tokenizer.sv
tb/tb.sv
